/* rtl/core/assert_macros.svh */
// assertion helpers for the instruction executor checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with asynchronous reset disable
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`endif

/* rtl/core/sve_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sve_pkg
// shared types, sizes and codes of the stack machine instruction executor
// ----------------------------------------------------------------------------
package sve_pkg;

  localparam int unsigned NUM_REGS         = 16;
  localparam int unsigned DATA_STACK_DEPTH = 64;
  localparam int unsigned CALL_STACK_DEPTH = 16;
  localparam int unsigned PROGRAM_SIZE     = 4096;

  localparam int unsigned RegAw  = $clog2(NUM_REGS);
  localparam int unsigned DsAw   = $clog2(DATA_STACK_DEPTH);
  localparam int unsigned CsAw   = $clog2(CALL_STACK_DEPTH);
  localparam int unsigned PcW    = $clog2(PROGRAM_SIZE);

  typedef enum logic [4:0] {
    OP_MOV = 5'd0, OP_PRN = 5'd1, OP_PCHR = 5'd2, OP_JMP = 5'd3,
    OP_ADD = 5'd4, OP_SUB = 5'd5, OP_MUL = 5'd6, OP_DIV = 5'd7,
    OP_MOD = 5'd8, OP_CMP = 5'd9, OP_JE = 5'd10, OP_JNE = 5'd11,
    OP_JG = 5'd12, OP_JGE = 5'd13, OP_JL = 5'd14, OP_JLE = 5'd15,
    OP_NOT = 5'd16, OP_AND = 5'd17, OP_OR = 5'd18, OP_XOR = 5'd19,
    OP_SHL = 5'd20, OP_SHR = 5'd21, OP_INC = 5'd22, OP_DEC = 5'd23,
    OP_CALL = 5'd24, OP_RET = 5'd25, OP_PUSH = 5'd26, OP_POP = 5'd27,
    OP_PUSHF = 5'd28, OP_POPF = 5'd29, OP_NOP = 5'd30, OP_RSVD = 5'd31
  } op_e;

  typedef enum logic [1:0] {
    FLAG_EQ = 2'd0, FLAG_GT = 2'd1, FLAG_LT = 2'd2, FLAG_NA = 2'd3
  } flag_e;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_DIV0 = 2'd1, ERR_OVF = 2'd2, ERR_UNF = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_DIV, ST_DONE
  } state_e;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage

/* rtl/core/stack_vm_instruction_execute.sv */
`timescale 1ns / 1ps
// sequence: an accepted instruction passes the read, execute and done states;
//   div and mod with a nonzero divisor wait in the div state for the divider (one quotient bit per cycle)
// throughput: one instruction at a time; input stall stays high until the
//   result transfer completes
// reset: registers, flag, stack pointers, pc and program base cleared
// ----------------------------------------------------------------------------
// stack_vm_instruction_execute
// sequenced executor around a register file, two stacks and a divider
// ----------------------------------------------------------------------------
module stack_vm_instruction_execute (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [11:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [4:0]  op_i,
  input  logic [3:0]  dest_reg_i,
  input  logic        src_is_reg_i,
  input  logic signed [31:0] src_value_i,
  input  logic        src2_is_reg_i,
  input  logic signed [31:0] src2_value_i,
  input  logic [11:0] jump_target_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [11:0] next_pc_o,
  output logic        print_valid_o,
  output logic        print_kind_o,
  output logic signed [31:0] print_value_o,
  output logic [1:0]  error_code_o
);

  localparam int unsigned RegAw = sve_pkg::RegAw;
  localparam int unsigned DsAw  = sve_pkg::DsAw;
  localparam int unsigned CsAw  = sve_pkg::CsAw;
  localparam int unsigned PcW   = sve_pkg::PcW;

  sve_pkg::state_e state_q, state_d;

  logic [11:0] base_q;
  logic [31:0] regs_q [sve_pkg::NUM_REGS];
  sve_pkg::flag_e flag_q, flag_d;
  logic [DsAw:0] dsp_q, dsp_d;
  logic [CsAw:0] csp_q, csp_d;
  logic [PcW-1:0] pc_q, pc_d;

  // latched instruction
  sve_pkg::op_e op_q;
  logic [3:0]  dst_q;
  logic [31:0] a_q, b_q, d_q;
  logic [11:0] tgt_q;
  logic        a_isr_q, b_isr_q;
  logic [31:0] a_raw_q, b_raw_q;

  // result registers
  logic [11:0] npc_q, npc_d;
  logic        pv_q, pv_d, pk_q, pk_d;
  logic [31:0] pval_q, pval_d;
  logic [1:0]  err_q, err_d;
  logic        wr_en;
  logic [31:0] wr_val;
  logic        done_q;

  // stacks
  logic          ds_we, cs_we;
  logic [DsAw-1:0] ds_addr;
  logic [CsAw-1:0] cs_addr;
  logic [31:0]   ds_wdata, ds_rdata;
  logic [PcW-1:0] cs_wdata, cs_rdata;

  sve_pkg::div_req_t div_req;
  sve_pkg::div_rsp_t div_rsp;

  function automatic logic [31:0] rd_op(input logic isr, input logic [31:0] v,
                                        input logic [31:0] rf [sve_pkg::NUM_REGS]);
    logic [31:0] r;
    r = v;
    if (isr) begin
      r = (v < 32'(sve_pkg::NUM_REGS)) ? rf[v[RegAw-1:0]] : '0;
    end
    return r;
  endfunction

  logic accept;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != sve_pkg::ST_IDLE);
  assign out_valid_o = done_q;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_we_i) begin
      base_q <= cfg_wdata_i;
    end
  end

  // capture instruction fields
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= sve_pkg::op_e'(op_i);
      dst_q   <= dest_reg_i;
      tgt_q   <= jump_target_i;
      a_isr_q <= src_is_reg_i;
      a_raw_q <= src_value_i;
      b_isr_q <= src2_is_reg_i;
      b_raw_q <= src2_value_i;
    end
    if (state_q == sve_pkg::ST_READ) begin
      a_q <= rd_op(a_isr_q, a_raw_q, regs_q);
      b_q <= rd_op(b_isr_q, b_raw_q, regs_q);
      d_q <= (32'(dst_q) < 32'(sve_pkg::NUM_REGS)) ? regs_q[dst_q[RegAw-1:0]] : '0;
    end
  end

  // stack addressing: pop and ret read the top entry during the read state
  always_comb begin
    ds_we = 1'b0; cs_we = 1'b0;
    ds_addr = dsp_q[DsAw-1:0]; cs_addr = csp_q[CsAw-1:0];
    ds_wdata = a_q; cs_wdata = '0;
    if (state_q == sve_pkg::ST_READ) begin
      ds_addr = dsp_q[DsAw-1:0] - DsAw'(1);
      cs_addr = csp_q[CsAw-1:0] - CsAw'(1);
    end
    if (state_q == sve_pkg::ST_EXEC && err_d == sve_pkg::ERR_NONE) begin
      if (op_q == sve_pkg::OP_PUSH || op_q == sve_pkg::OP_PUSHF) begin
        ds_we    = 1'b1;
        ds_wdata = (op_q == sve_pkg::OP_PUSH) ? a_q : {30'd0, flag_q};
      end
      if (op_q == sve_pkg::OP_CALL) begin
        cs_we    = 1'b1;
        cs_wdata = pc_q + PcW'(1) - PcW'(base_q);
      end
    end
  end

  sve_ram #(.Width(32), .Depth(sve_pkg::DATA_STACK_DEPTH)) u_ds (
    .clk_i, .we_i(ds_we), .addr_i(ds_addr), .wdata_i(ds_wdata), .rdata_o(ds_rdata)
  );
  sve_ram #(.Width(PcW), .Depth(sve_pkg::CALL_STACK_DEPTH)) u_cs (
    .clk_i, .we_i(cs_we), .addr_i(cs_addr), .wdata_i(cs_wdata), .rdata_o(cs_rdata)
  );

  sve_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // execute datapath and sequencer
  always_comb begin
    logic taken;
    logic [PcW-1:0] seq, tgt;
    logic [31:0] fill;
    logic signed [31:0] sa, sb;
    state_d = state_q;
    flag_d = flag_q; dsp_d = dsp_q; csp_d = csp_q; pc_d = pc_q;
    npc_d = npc_q; pv_d = pv_q; pk_d = pk_q; pval_d = pval_q; err_d = err_q;
    wr_en = 1'b0; wr_val = '0; taken = 1'b0;
    seq = pc_q + PcW'(1); tgt = PcW'(tgt_q);
    fill = {32{d_q[31]}};
    sa = a_q; sb = b_q;
    div_req.start = 1'b0;
    div_req.is_mod = (op_q == sve_pkg::OP_MOD);
    div_req.dividend = d_q; div_req.divisor = a_q;
    case (state_q)
      sve_pkg::ST_IDLE: if (accept) state_d = sve_pkg::ST_READ;
      sve_pkg::ST_READ: state_d = sve_pkg::ST_EXEC;
      sve_pkg::ST_EXEC, sve_pkg::ST_DIV: begin
        pv_d = 1'b0; pk_d = 1'b0; pval_d = '0; err_d = sve_pkg::ERR_NONE;
        state_d = sve_pkg::ST_DONE;
        case (op_q)
          sve_pkg::OP_MOV:  begin wr_en = 1'b1; wr_val = a_q; end
          sve_pkg::OP_PRN:  begin pv_d = 1'b1; pval_d = a_q; end
          sve_pkg::OP_PCHR: begin pv_d = 1'b1; pk_d = 1'b1; pval_d = {24'd0, a_q[7:0]}; end
          sve_pkg::OP_JMP:  taken = 1'b1;
          sve_pkg::OP_ADD:  begin wr_en = 1'b1; wr_val = d_q + a_q; end
          sve_pkg::OP_SUB:  begin wr_en = 1'b1; wr_val = d_q - a_q; end
          sve_pkg::OP_MUL:  begin wr_en = 1'b1; wr_val = d_q * a_q; end
          sve_pkg::OP_DIV, sve_pkg::OP_MOD: begin
            if (a_q == '0) begin
              err_d = sve_pkg::ERR_DIV0;
            end else if (state_q == sve_pkg::ST_EXEC) begin
              div_req.start = 1'b1;
              state_d = sve_pkg::ST_DIV;
            end else if (!div_rsp.done) begin
              state_d = sve_pkg::ST_DIV;
            end else begin
              wr_en = 1'b1; wr_val = div_rsp.result;
            end
          end
          sve_pkg::OP_CMP:  flag_d = (sa > sb) ? sve_pkg::FLAG_GT :
                                     (sa < sb) ? sve_pkg::FLAG_LT : sve_pkg::FLAG_EQ;
          sve_pkg::OP_JE:   taken = (flag_q == sve_pkg::FLAG_EQ);
          sve_pkg::OP_JNE:  taken = (flag_q != sve_pkg::FLAG_EQ);
          sve_pkg::OP_JG:   taken = (flag_q == sve_pkg::FLAG_GT);
          sve_pkg::OP_JGE:  taken = (flag_q == sve_pkg::FLAG_EQ) || (flag_q == sve_pkg::FLAG_GT);
          sve_pkg::OP_JL:   taken = (flag_q == sve_pkg::FLAG_LT);
          sve_pkg::OP_JLE:  taken = (flag_q == sve_pkg::FLAG_EQ) || (flag_q == sve_pkg::FLAG_LT);
          sve_pkg::OP_NOT:  begin wr_en = 1'b1; wr_val = ~d_q; end
          sve_pkg::OP_AND:  begin wr_en = 1'b1; wr_val = d_q & a_q; end
          sve_pkg::OP_OR:   begin wr_en = 1'b1; wr_val = d_q | a_q; end
          sve_pkg::OP_XOR:  begin wr_en = 1'b1; wr_val = d_q ^ a_q; end
          sve_pkg::OP_SHL:  begin
            wr_en = 1'b1; wr_val = (a_q >= 32'd32) ? '0 : (d_q << a_q[4:0]);
          end
          sve_pkg::OP_SHR:  begin
            wr_en = 1'b1;
            wr_val = (a_q >= 32'd32) ? fill : 32'($signed(d_q) >>> a_q[4:0]);
          end
          sve_pkg::OP_INC:  begin wr_en = 1'b1; wr_val = d_q + 32'd1; end
          sve_pkg::OP_DEC:  begin wr_en = 1'b1; wr_val = d_q - 32'd1; end
          sve_pkg::OP_CALL: begin
            if (csp_q >= (CsAw+1)'(sve_pkg::CALL_STACK_DEPTH)) begin
              err_d = sve_pkg::ERR_OVF;
            end else begin
              csp_d = csp_q + (CsAw+1)'(1); taken = 1'b1;
            end
          end
          sve_pkg::OP_RET:  begin
            if (csp_q == '0) begin
              err_d = sve_pkg::ERR_UNF;
            end else begin
              csp_d = csp_q - (CsAw+1)'(1); taken = 1'b1; tgt = cs_rdata;
            end
          end
          sve_pkg::OP_PUSH, sve_pkg::OP_PUSHF: begin
            if (dsp_q >= (DsAw+1)'(sve_pkg::DATA_STACK_DEPTH)) begin
              err_d = sve_pkg::ERR_OVF;
            end else begin
              dsp_d = dsp_q + (DsAw+1)'(1);
            end
          end
          sve_pkg::OP_POP:  begin
            if (dsp_q == '0) begin
              err_d = sve_pkg::ERR_UNF;
            end else begin
              dsp_d = dsp_q - (DsAw+1)'(1); wr_en = 1'b1; wr_val = ds_rdata;
            end
          end
          sve_pkg::OP_POPF: begin wr_en = 1'b1; wr_val = {30'd0, flag_q}; end
          default: ;
        endcase
        if (state_d == sve_pkg::ST_DONE) begin
          if (err_d != sve_pkg::ERR_NONE) begin
            npc_d = 12'(pc_q); wr_en = 1'b0;
          end else begin
            pc_d  = taken ? (PcW'(base_q) + tgt) : seq;
            npc_d = 12'(pc_d);
          end
        end else begin
          wr_en = 1'b0;
        end
      end
      sve_pkg::ST_DONE: if (!out_stall_i) state_d = sve_pkg::ST_IDLE;
      default: state_d = sve_pkg::ST_IDLE;
    endcase
  end

  // state and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sve_pkg::ST_IDLE;
      flag_q  <= sve_pkg::FLAG_EQ;
      dsp_q   <= '0;
      csp_q   <= '0;
      pc_q    <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < int'(sve_pkg::NUM_REGS); i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      flag_q  <= flag_d;
      dsp_q   <= dsp_d;
      csp_q   <= csp_d;
      pc_q    <= pc_d;
      done_q  <= (state_d == sve_pkg::ST_DONE);
      if (wr_en && (32'(dst_q) < 32'(sve_pkg::NUM_REGS))) regs_q[dst_q[RegAw-1:0]] <= wr_val;
    end
  end

  always_ff @(posedge clk_i) begin
    npc_q <= npc_d; pv_q <= pv_d; pk_q <= pk_d; pval_q <= pval_d; err_q <= err_d;
  end

  assign next_pc_o     = npc_q;
  assign print_valid_o = pv_q;
  assign print_kind_o  = pk_q;
  assign print_value_o = pval_q;
  assign error_code_o  = err_q;

endmodule

/* rtl/core/sve_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sve_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module sve_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/core/sve_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sve_div
// signed restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module sve_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sve_pkg::div_req_t req_i,
  output sve_pkg::div_rsp_t rsp_o
);

  logic [31:0] quo_q, quo_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        neg_q_q, neg_q_d, neg_r_q, neg_r_d, mod_q, mod_d;
  logic [32:0] trial;
  logic [31:0] quo_out, rem_out;

  assign trial = {rem_q[31:0], quo_q[31]} - {1'b0, dvs_q};

  // iteration step
  always_comb begin
    quo_d = quo_q; rem_d = rem_q; dvs_d = dvs_q; cnt_d = cnt_q; busy_d = busy_q;
    neg_q_d = neg_q_q; neg_r_d = neg_r_q; mod_d = mod_q;
    if (req_i.start) begin
      quo_d   = req_i.dividend[31] ? (~req_i.dividend + 32'd1) : req_i.dividend;
      dvs_d   = req_i.divisor[31] ? (~req_i.divisor + 32'd1) : req_i.divisor;
      rem_d   = '0;
      cnt_d   = 6'd32;
      busy_d  = 1'b1;
      neg_q_d = req_i.dividend[31] ^ req_i.divisor[31];
      neg_r_d = req_i.dividend[31];
      mod_d   = req_i.is_mod;
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = {rem_q[31:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial;
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; dvs_q <= dvs_d;
    neg_q_q <= neg_q_d; neg_r_q <= neg_r_d; mod_q <= mod_d;
  end

  // sign correction of the magnitudes
  assign quo_out = neg_q_q ? (~quo_q + 32'd1) : quo_q;
  assign rem_out = neg_r_q ? (~rem_q[31:0] + 32'd1) : rem_q[31:0];
  assign rsp_o.done   = !busy_q && (cnt_q == 6'd0);
  assign rsp_o.result = mod_q ? rem_out : quo_out;

endmodule

/* rtl/core/sve_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sve_checker
// port level checks of the instruction executor
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sve_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        print_valid_o,
  input logic [1:0]  error_code_o,
  input logic [11:0] next_pc_o
);

  // a new transfer is not taken while a result is pending
  `ASSERT_CLK(a_no_overlap, clk_i, rst_ni, out_valid_o |-> in_stall_o, "input taken with result pending")
  // errors never print
  `ASSERT_CLK(a_err_noprint, clk_i, rst_ni, (out_valid_o && error_code_o != sve_pkg::ERR_NONE) |-> !print_valid_o, "print on error")
  // stalled result holds
  `ASSERT_CLK(a_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(next_pc_o)), "result dropped")
  // after transfer the block is busy
  `ASSERT_CLK(a_busy, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o, "not busy after transfer")

endmodule

bind stack_vm_instruction_execute sve_checker u_sve_checker (.*);
